/* hw/rtl/bls_pkg.sv */
`timescale 1ns / 1ps

package bls_pkg;

  // Default coordinate width of the stepper.
  localparam int COORD_BITS_DEF = 12;

  // Depth of the queue between the decode front and the stepping back end.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Request kinds carried in the input tuser bit.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

endpackage

/* hw/rtl/bresenham_line_stepper.sv */
`timescale 1ns / 1ps

// Integer Bresenham line stepper for all octants. A start request (tuser 0)
// loads both endpoints and returns the first pixel; each advance request
// (tuser 1) returns the next pixel, with tlast on the end point. An advance
// with no line in progress returns a result whose tuser is 0 and whose data
// is zero. While the output is not stalled, the block sustains one request per
// clock: the front decodes each request and computes deltas, directions and
// the initial error term, a four-entry queue decouples it from the back end,
// and the back end performs one error-term update per clock into a registered
// output. Each request passes through the queue and then the output register
// before its result shows on the output.
module bresenham_line_stepper #(
  parameter int COORD_BITS  = bls_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = bls_pkg::QUEUE_DEPTH_DEF,
  parameter int IN_DW       = ((4 * COORD_BITS + 7) / 8) * 8,
  parameter int OUT_DW      = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  input  logic              in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // pixel_x, pixel_y
  output logic              out_tuser,  // valid_res
  output logic              out_tlast
);
  import bls_pkg::*;

  localparam int C          = COORD_BITS;
  localparam int ENTRY_BITS = 7 * C + 5;

  logic [ENTRY_BITS-1:0] wr_entry;
  logic [ENTRY_BITS-1:0] rd_entry;
  logic                  q_valid;
  logic                  q_ready;
  logic [C-1:0]          px;
  logic [C-1:0]          py;

  bls_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .req_op      (in_tuser),
    .req_start_x (in_tdata[C-1:0]),
    .req_start_y (in_tdata[2*C-1:C]),
    .req_end_x   (in_tdata[3*C-1:2*C]),
    .req_end_y   (in_tdata[4*C-1:3*C]),
    .entry       (wr_entry)
  );

  bls_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (wr_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (rd_entry)
  );

  bls_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (rd_entry),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_valid_res (out_tuser),
    .res_pixel_x   (px),
    .res_pixel_y   (py),
    .res_last      (out_tlast)
  );

  // Pack the pixel with zero fill up to whole bytes.
  assign out_tdata = OUT_DW'({py, px});

endmodule

/* hw/rtl/bls_front.sv */
`timescale 1ns / 1ps

module bls_front #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int ENTRY_BITS = 7 * COORD_BITS + 5
) (
  input  logic                  req_op,
  input  logic [COORD_BITS-1:0] req_start_x,
  input  logic [COORD_BITS-1:0] req_start_y,
  input  logic [COORD_BITS-1:0] req_end_x,
  input  logic [COORD_BITS-1:0] req_end_y,
  output logic [ENTRY_BITS-1:0] entry
);
  import bls_pkg::*;

  localparam int EB = COORD_BITS + 2;

  logic                  is_start;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  sx_neg;
  logic                  sy_neg;
  logic [EB-1:0]         err0;

  // Classify the request and work out the line setup for a start request.
  always_comb begin
    is_start = (req_op == OP_START);
    if (req_end_x >= req_start_x) begin
      dx = req_end_x - req_start_x;
    end else begin
      dx = req_start_x - req_end_x;
    end
    if (req_end_y >= req_start_y) begin
      dy = req_end_y - req_start_y;
    end else begin
      dy = req_start_y - req_end_y;
    end
    sx_neg = (req_start_x >= req_end_x);
    sy_neg = (req_start_y >= req_end_y);
    err0   = {2'b00, dx} - {2'b00, dy};
  end

  // Queue entry, lowest bit first: start flag, x0, y0, x1, y1, dx, dy,
  // x direction, y direction, initial error term.
  assign entry = {err0, sy_neg, sx_neg, dy, dx,
                  req_end_y, req_end_x, req_start_y, req_start_x, is_start};

endmodule

/* hw/rtl/bls_queue.sv */
`timescale 1ns / 1ps

module bls_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bls_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/bls_back.sv */
`timescale 1ns / 1ps

module bls_back #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int ENTRY_BITS = 7 * COORD_BITS + 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [ENTRY_BITS-1:0] q_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_valid_res,
  output logic [COORD_BITS-1:0] res_pixel_x,
  output logic [COORD_BITS-1:0] res_pixel_y,
  output logic                  res_last
);
  import bls_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int EB = C + 2;
  localparam int WB = C + 3;

  // Unpacked queue entry.
  logic          e_start;
  logic [C-1:0]  e_x0, e_y0, e_x1, e_y1, e_dx, e_dy;
  logic          e_sx, e_sy;
  logic [EB-1:0] e_err;

  assign {e_err, e_sy, e_sx, e_dy, e_dx, e_y1, e_x1, e_y0, e_x0, e_start} = q_data;

  // Line state.
  logic [C-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [C-1:0]  tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [C-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic          sx_r, sx_nxt, sy_r, sy_nxt;
  logic [EB-1:0] err_r, err_nxt;
  logic          active_r, active_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic          out_res_r, out_res_nxt;
  logic [C-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic          out_last_r, out_last_nxt;

  // Step arithmetic.
  logic          pop;
  logic [WB-1:0] e2, dx_w, dy_w, err_w, acc_w;
  logic          step_x, step_y;
  logic [C-1:0]  nx, ny;
  logic          at_end;

  assign q_ready = !out_valid_r || res_ready;
  assign pop     = q_valid && q_ready;

  // One Bresenham step from the current state.
  always_comb begin
    e2     = {err_r, 1'b0};
    dx_w   = {3'b000, dx_r};
    dy_w   = {3'b000, dy_r};
    err_w  = {err_r[EB-1], err_r};
    step_x = $signed(e2) > $signed(-dy_w);
    step_y = $signed(e2) < $signed(dx_w);
    acc_w  = err_w;
    nx     = cur_x_r;
    ny     = cur_y_r;
    if (step_x) begin
      acc_w = acc_w - dy_w;
      nx    = sx_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    end
    if (step_y) begin
      acc_w = acc_w + dx_w;
      ny    = sy_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  // Request execution and result formation.
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    err_nxt       = err_r;
    active_nxt    = active_r;
    out_res_nxt   = out_res_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !res_ready;
    at_end        = 1'b0;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (e_start) begin
        at_end       = (e_x0 == e_x1) && (e_y0 == e_y1);
        cur_x_nxt    = e_x0;
        cur_y_nxt    = e_y0;
        tgt_x_nxt    = e_x1;
        tgt_y_nxt    = e_y1;
        dx_nxt       = e_dx;
        dy_nxt       = e_dy;
        sx_nxt       = e_sx;
        sy_nxt       = e_sy;
        err_nxt      = e_err;
        active_nxt   = !at_end;
        out_res_nxt  = 1'b1;
        out_x_nxt    = e_x0;
        out_y_nxt    = e_y0;
        out_last_nxt = at_end;
      end else if (active_r) begin
        at_end       = (nx == tgt_x_r) && (ny == tgt_y_r);
        cur_x_nxt    = nx;
        cur_y_nxt    = ny;
        err_nxt      = acc_w[EB-1:0];
        active_nxt   = !at_end;
        out_res_nxt  = 1'b1;
        out_x_nxt    = nx;
        out_y_nxt    = ny;
        out_last_nxt = at_end;
      end else begin
        out_res_nxt  = 1'b0;
        out_x_nxt    = '0;
        out_y_nxt    = '0;
        out_last_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Line state and result payload.
  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    tgt_x_r    <= tgt_x_nxt;
    tgt_y_r    <= tgt_y_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    err_r      <= err_nxt;
    out_res_r  <= out_res_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign res_valid     = out_valid_r;
  assign res_valid_res = out_res_r;
  assign res_pixel_x   = out_x_r;
  assign res_pixel_y   = out_y_r;
  assign res_last      = out_last_r;

`ifndef ASSERT_OFF
  // An idle advance gives an all-zero result.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r) |-> (out_x_r == '0 && out_y_r == '0 && !out_last_r))
    else $error("idle result carries a nonzero pixel");

  // Giving the end point leaves the stepper idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && out_last_nxt) |=> !active_r)
    else $error("stepper still active after the end point");

  // An advance taken while idle yields no pixel.
  a_advance_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !e_start && !active_r) |=> (out_valid_r && !out_res_r))
    else $error("advance while idle produced a pixel");

  // While a line is active the current point differs from the end point.
  a_active_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !(cur_x_r == tgt_x_r && cur_y_r == tgt_y_r))
    else $error("active line already sits on its end point");
`endif

endmodule
